// File: rtl/core/lqu_pkg.sv
package lqu_pkg;

	localparam int ENTRIES = 32;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int ID_W    = 5;
	localparam int CNT_W   = 6;

	// command queue between front and back
	localparam int QDEPTH  = 2;
	localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W  = $clog2(QDEPTH + 1);
	localparam int PEND_W  = QCNT_W;

	typedef enum logic [1:0] {
		KIND_APPEND = 2'd0,
		KIND_POP    = 2'd1,
		KIND_UNLINK = 2'd2,
		KIND_PEEK   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_DONE = 2'd0,
		ST_MISS = 2'd1,
		ST_DUP  = 2'd2
	} status_t;

	typedef struct packed {
		kind_t             kind;
		logic [ID_W-1:0]   entry_id;
	} req_t;

	typedef struct packed {
		status_t           status;
		logic [ID_W-1:0]   entry_out;
		logic              now_empty;
		logic [CNT_W-1:0]  occupancy;
	} rsp_t;

	// classified request, as handed from front to back
	typedef struct packed {
		kind_t             kind;
		logic [ID_W-1:0]   entry_id;
		status_t           status;
		logic [CNT_W-1:0]  occupancy;
	} cmd_t;

	// back tells front which entry left the head
	typedef struct packed {
		logic              valid;
		logic [IDX_W-1:0]  idx;
	} flag_clr_t;

endpackage

// File: rtl/core/lqu_ram.sv
module lqu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                          clk,
	input  logic                                          we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
	input  logic [WIDTH-1:0]                              wdata,
	input  logic                                          re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
	output logic [WIDTH-1:0]                              rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/core/lqu_front.sv
module lqu_front import lqu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  req_t       req,
	output logic       push,
	output cmd_t       push_word,
	input  logic       q_full,
	input  flag_clr_t  clr
);
	logic [ENTRIES-1:0] flag_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [PEND_W-1:0]  pend_q;

	logic [IDX_W-1:0]   id_idx;
	logic               in_rng;
	logic               hit;
	logic               needs_flags;
	status_t            st;
	logic [CNT_W-1:0]   cnt_d;
	logic               set_flag;
	logic               clr_flag;
	logic               pend_inc;

	always_comb begin
		id_idx      = IDX_W'(req.entry_id);
		in_rng      = 32'(req.entry_id) < 32'(ENTRIES);
		hit         = in_rng && flag_q[id_idx];
		// flags lag while a pop waits for the back to name the head
		needs_flags = (req.kind == KIND_APPEND) || (req.kind == KIND_UNLINK);
		req_ready   = !q_full && !(needs_flags && (pend_q != '0));
		push        = req_valid && req_ready;

		st       = ST_MISS;
		cnt_d    = cnt_q;
		set_flag = 1'b0;
		clr_flag = 1'b0;
		pend_inc = 1'b0;
		unique case (req.kind)
			KIND_APPEND: begin
				if (!in_rng) begin
					st = ST_MISS;
				end else if (hit) begin
					st = ST_DUP;
				end else begin
					st       = ST_DONE;
					set_flag = 1'b1;
					cnt_d    = cnt_q + CNT_W'(1);
				end
			end
			KIND_POP: begin
				if (cnt_q != '0) begin
					st       = ST_DONE;
					cnt_d    = cnt_q - CNT_W'(1);
					pend_inc = 1'b1;
				end
			end
			KIND_UNLINK: begin
				if (hit) begin
					st       = ST_DONE;
					clr_flag = 1'b1;
					cnt_d    = cnt_q - CNT_W'(1);
				end
			end
			KIND_PEEK: begin
				if (cnt_q != '0) begin
					st = ST_DONE;
				end
			end
			default: begin
				st = ST_MISS;
			end
		endcase

		push_word.kind      = req.kind;
		push_word.entry_id  = req.entry_id;
		push_word.status    = st;
		push_word.occupancy = cnt_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q <= '0;
			cnt_q  <= '0;
			pend_q <= '0;
		end else begin
			if (push) begin
				cnt_q <= cnt_d;
				if (set_flag) begin
					flag_q[id_idx] <= 1'b1;
				end
				if (clr_flag) begin
					flag_q[id_idx] <= 1'b0;
				end
			end
			if (clr.valid) begin
				flag_q[clr.idx] <= 1'b0;
			end
			pend_q <= pend_q + PEND_W'(push && pend_inc) - PEND_W'(clr.valid);
		end
	end

endmodule

// File: rtl/core/lqu_cmdq.sv
module lqu_cmdq import lqu_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  cmd_t  push_word,
	output logic  full,
	output logic  q_valid,
	output cmd_t  q_word,
	input  logic  pop
);
	cmd_t               slot_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_q;
	logic [QPTR_W-1:0]  rd_q;
	logic [QCNT_W-1:0]  cnt_q;

	function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
		logic [QPTR_W-1:0] n;
		n = (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
		return n;
	endfunction

	assign full    = (cnt_q == QCNT_W'(QDEPTH));
	assign q_valid = (cnt_q != '0);
	assign q_word  = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= bump(wr_q);
			end
			if (pop) begin
				rd_q <= bump(rd_q);
			end
			cnt_q <= cnt_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

endmodule

// File: rtl/core/lqu_back.sv
module lqu_back import lqu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  cmd_t       q_word,
	output logic       pop,
	output flag_clr_t  clr,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output rsp_t       rsp
);
	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_FIN  = 2'b10
	} state_t;

	state_t            state_q, state_d;
	logic [IDX_W-1:0]  head_q, head_d;
	logic [IDX_W-1:0]  tail_q, tail_d;
	cmd_t              cmd_s2;
	logic              load_s2;
	rsp_t              rsp_q, rsp_d;
	logic              rsp_valid_q;
	logic              emit;
	logic              out_free;

	logic              re;
	logic [IDX_W-1:0]  raddr;
	logic              nx_we, pv_we;
	logic [IDX_W-1:0]  nx_waddr, pv_waddr;
	logic [IDX_W-1:0]  nx_wdata, pv_wdata;
	logic [IDX_W-1:0]  nx_rdata, pv_rdata;
	logic [IDX_W-1:0]  id_idx, id2_idx;
	logic              is_long;

	lqu_ram #(.WIDTH(IDX_W), .DEPTH(ENTRIES)) u_next (
		.clk   (clk),
		.we    (nx_we),
		.waddr (nx_waddr),
		.wdata (nx_wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (nx_rdata)
	);

	lqu_ram #(.WIDTH(IDX_W), .DEPTH(ENTRIES)) u_prev (
		.clk   (clk),
		.we    (pv_we),
		.waddr (pv_waddr),
		.wdata (pv_wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (pv_rdata)
	);

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		id_idx   = IDX_W'(q_word.entry_id);
		id2_idx  = IDX_W'(cmd_s2.entry_id);
		is_long  = (q_word.status == ST_DONE) &&
		           ((q_word.kind == KIND_POP) || (q_word.kind == KIND_UNLINK));

		state_d  = state_q;
		head_d   = head_q;
		tail_d   = tail_q;
		pop      = 1'b0;
		load_s2  = 1'b0;
		emit     = 1'b0;
		rsp_d    = rsp_q;
		clr      = '0;
		re       = 1'b0;
		raddr    = head_q;
		nx_we    = 1'b0;
		pv_we    = 1'b0;
		nx_waddr = tail_q;
		nx_wdata = id_idx;
		pv_waddr = id_idx;
		pv_wdata = tail_q;

		unique case (state_q)
			S_IDLE: begin
				if (q_valid && is_long) begin
					// fetch both links of the entry leaving
					pop     = 1'b1;
					load_s2 = 1'b1;
					re      = 1'b1;
					raddr   = (q_word.kind == KIND_POP) ? head_q : id_idx;
					if (q_word.kind == KIND_POP) begin
						clr.valid = 1'b1;
						clr.idx   = head_q;
					end
					state_d = S_FIN;
				end else if (q_valid && out_free) begin
					pop             = 1'b1;
					emit            = 1'b1;
					rsp_d.status    = q_word.status;
					rsp_d.entry_out = '0;
					rsp_d.now_empty = (q_word.occupancy == '0);
					rsp_d.occupancy = q_word.occupancy;
					if (q_word.status == ST_DONE) begin
						if (q_word.kind == KIND_APPEND) begin
							rsp_d.entry_out = q_word.entry_id;
							if (q_word.occupancy == CNT_W'(1)) begin
								head_d = id_idx;
							end else begin
								nx_we = 1'b1;
								pv_we = 1'b1;
							end
							tail_d = id_idx;
						end else begin
							rsp_d.entry_out = ID_W'(head_q);
						end
					end
				end
			end
			S_FIN: begin
				if (out_free) begin
					emit            = 1'b1;
					rsp_d.status    = ST_DONE;
					rsp_d.now_empty = (cmd_s2.occupancy == '0);
					rsp_d.occupancy = cmd_s2.occupancy;
					if (cmd_s2.kind == KIND_POP) begin
						rsp_d.entry_out = ID_W'(head_q);
						if (cmd_s2.occupancy != '0) begin
							head_d = nx_rdata;
						end
					end else begin
						rsp_d.entry_out = cmd_s2.entry_id;
						// splice neighbors around the unlinked entry
						if (id2_idx == head_q) begin
							head_d = nx_rdata;
						end else begin
							nx_we    = 1'b1;
							nx_waddr = pv_rdata;
							nx_wdata = nx_rdata;
						end
						if (id2_idx == tail_q) begin
							tail_d = pv_rdata;
						end else begin
							pv_we    = 1'b1;
							pv_waddr = nx_rdata;
							pv_wdata = pv_rdata;
						end
					end
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			cmd_s2 <= q_word;
		end
		if (emit) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: rtl/core/linked_queue_with_unlink.sv
// Path: an accepted request is written to the command queue; append, peek and refused
// words are then answered from S_IDLE into the output register, pop-head and unlink via
// S_FIN (one link-RAM read, then the write-back). Throughput: back end retires one word
// per cycle while the output register is free, but a removal holds it in S_FIN before
// the next word; a two-deep command queue absorbs bursts. Reset (arst_n low): queue
// empty, membership flags cleared, head/tail zero; link RAM contents are not reset.
module linked_queue_with_unlink import lqu_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  req_valid,
	output logic  req_ready,
	input  req_t  req,
	output logic  rsp_valid,
	input  logic  rsp_ready,
	output rsp_t  rsp
);
	// front -> queue
	logic       push;
	cmd_t       push_word;
	logic       q_full;

	// queue -> back
	logic       q_valid;
	cmd_t       q_word;
	logic       pop;

	// back -> front: entry that left the head, so its membership flag drops
	flag_clr_t  clr;

	// Front end: owns membership flags and the entry count, so status, occupancy
	// and empty are settled at acceptance. Append/unlink words wait while a
	// pop-head is still in flight, since the popped entry is not known yet.
	lqu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.push      (push),
		.push_word (push_word),
		.q_full    (q_full),
		.clr       (clr)
	);

	// Classified commands, in order.
	lqu_cmdq u_cmdq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.full      (q_full),
		.q_valid   (q_valid),
		.q_word    (q_word),
		.pop       (pop)
	);

	// Back end: head/tail pointers and next/prev link RAMs; fills in the entry
	// number and holds the result in an output register.
	lqu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_word    (q_word),
		.pop       (pop),
		.clr       (clr),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

// File: tb/tb_linked_queue_with_unlink.sv
module tb_linked_queue_with_unlink;
	import lqu_pkg::*;

	// Scoreboard: mirrors the linked queue and keeps the words still owed on rsp.
	class queue_scoreboard;
		logic [ID_W-1:0]  next_lnk [ENTRIES];
		logic [ID_W-1:0]  prev_lnk [ENTRIES];
		bit               member   [ENTRIES];
		logic [ID_W-1:0]  head;
		logic [ID_W-1:0]  tail;
		logic [CNT_W-1:0] count;
		rsp_t             rsp_due[$];
		int               fails;

		function new();
			for (int i = 0; i < ENTRIES; i++) begin
				next_lnk[i] = '0;
				prev_lnk[i] = '0;
				member[i]   = 1'b0;
			end
			head  = '0;
			tail  = '0;
			count = '0;
			fails = 0;
		endfunction

		function int pending();
			return rsp_due.size();
		endfunction

		// next state and the word that one request produces
		function rsp_t queue_step(req_t w);
			rsp_t             r;
			logic [ID_W-1:0]  id;
			logic [ID_W-1:0]  e;
			logic [ID_W-1:0]  bef;
			logic [ID_W-1:0]  aft;
			bit               fits;
			r         = '0;
			r.status  = ST_MISS;
			id        = w.entry_id;
			fits      = int'(id) < ENTRIES;
			case (w.kind)
				KIND_APPEND: begin
					if (fits && member[id]) begin
						r.status = ST_DUP;
					end else if (fits) begin
						if (count == 0) begin
							head = id;
						end else begin
							next_lnk[tail] = id;
							prev_lnk[id]   = tail;
						end
						tail       = id;
						member[id] = 1'b1;
						count      = count + 1'b1;
						r.status   = ST_DONE;
						r.entry_out = id;
					end
				end
				KIND_POP: begin
					if (count != 0) begin
						e         = head;
						count     = count - 1'b1;
						member[e] = 1'b0;
						if (count != 0)
							head = next_lnk[e];
						r.status    = ST_DONE;
						r.entry_out = e;
					end
				end
				KIND_UNLINK: begin
					if (fits && member[id]) begin
						bef = prev_lnk[id];
						aft = next_lnk[id];
						// head/tail: the pointer moves, the far-side link is not touched
						if (id == head)
							head = aft;
						else
							next_lnk[bef] = aft;
						if (id == tail)
							tail = bef;
						else
							prev_lnk[aft] = bef;
						member[id]  = 1'b0;
						count       = count - 1'b1;
						r.status    = ST_DONE;
						r.entry_out = id;
					end
				end
				default: begin
					if (count != 0) begin
						r.status    = ST_DONE;
						r.entry_out = head;
					end
				end
			endcase
			r.now_empty = (count == 0);
			r.occupancy = count;
			return r;
		endfunction

		function void note(req_t w);
			rsp_due.push_back(queue_step(w));
		endfunction

		task report(string what, int got, int want);
			if (fails < 50)
				$display("mismatch: %s got %0d want %0d", what, got, want);
			fails++;
		endtask

		task check(rsp_t got);
			rsp_t want;
			if (rsp_due.size() == 0) begin
				report("unexpected rsp word", int'(got), 0);
				return;
			end
			want = rsp_due.pop_front();
			if (got.status !== want.status)
				report("status", int'(got.status), int'(want.status));
			if (got.entry_out !== want.entry_out)
				report("entry_out", int'(got.entry_out), int'(want.entry_out));
			if (got.now_empty !== want.now_empty)
				report("now_empty", int'(got.now_empty), int'(want.now_empty));
			if (got.occupancy !== want.occupancy)
				report("occupancy", int'(got.occupancy), int'(want.occupancy));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	queue_scoreboard sb = new();

	// per-phase idle limits; hold_rsp asks the receiver for one long stall
	int req_gap_max = 10;
	int rsp_gap_max = 10;
	bit hold_rsp    = 1'b0;

	linked_queue_with_unlink dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Runaway guard: roughly 4x the slowest legal run (about 2k words, each with
	// a full sender gap, the unlink path through S_FIN and a full receiver stall).
	initial begin
		#2000000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic req_t mk_word(kind_t k, logic [ID_W-1:0] id);
		req_t w;
		w.kind     = k;
		w.entry_id = id;
		return w;
	endfunction

	// random entry that is (or is not) queued right now; falls back to any entry
	function automatic logic [ID_W-1:0] pick_entry(bit want_queued);
		int start;
		int idx;
		start = $urandom_range(0, ENTRIES - 1);
		for (int k = 0; k < ENTRIES; k++) begin
			idx = (start + k) % ENTRIES;
			if (sb.member[idx] == want_queued)
				return idx[ID_W-1:0];
		end
		return start[ID_W-1:0];
	endfunction

	// Mostly legal traffic so the list actually grows, shrinks and gets cut in
	// the middle; fill phases push toward 32 entries, drain phases toward empty.
	function automatic req_t random_word(bit draining);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 10)
			return mk_word(kind_t'($urandom_range(0, 3)), ID_W'($urandom_range(0, 31)));
		if (!draining) begin
			if (roll < 65) return mk_word(KIND_APPEND, pick_entry(1'b0));
			if (roll < 73) return mk_word(KIND_APPEND, pick_entry(1'b1));
			if (roll < 83) return mk_word(KIND_POP, ID_W'($urandom_range(0, 31)));
			if (roll < 93) return mk_word(KIND_UNLINK, pick_entry(1'b1));
		end else begin
			if (roll < 25) return mk_word(KIND_APPEND, pick_entry(1'b0));
			if (roll < 55) return mk_word(KIND_POP, ID_W'($urandom_range(0, 31)));
			if (roll < 85) return mk_word(KIND_UNLINK, pick_entry(1'b1));
			if (roll < 90) return mk_word(KIND_UNLINK, pick_entry(1'b0));
		end
		return mk_word(KIND_PEEK, ID_W'($urandom_range(0, 31)));
	endfunction

	// Offer one word; valid only drops when a gap is drawn, so it never
	// falls and rises within one step.
	task automatic send_word(input req_t w);
		int gap;
		gap = $urandom_range(0, req_gap_max);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req       <= w;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		sb.note(w);
	endtask

	// sender goes quiet until every owed word has come back
	task automatic wait_drained();
		req_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	// Receiver: draws a stall after each accepted word, or a long one on request.
	initial begin : rsp_side
		int stall;
		stall = 0;
		rsp_ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			@(posedge clk);
			if (rsp_valid && rsp_ready) begin
				sb.check(rsp);
				stall = $urandom_range(0, rsp_gap_max);
			end
			if (hold_rsp) begin
				hold_rsp = 1'b0;
				stall    = 400;
			end
			if (stall > 0) begin
				stall--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	initial begin : req_side
		req_t directed[$];
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req       <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue: peek, pop and unlink all miss
		directed.push_back(mk_word(KIND_PEEK,   5'd0));
		directed.push_back(mk_word(KIND_POP,    5'd31));
		directed.push_back(mk_word(KIND_UNLINK, 5'd0));
		// extremes of entry_id, then duplicates refused
		directed.push_back(mk_word(KIND_APPEND, 5'd0));
		directed.push_back(mk_word(KIND_APPEND, 5'd31));
		directed.push_back(mk_word(KIND_APPEND, 5'd0));
		directed.push_back(mk_word(KIND_APPEND, 5'd31));
		directed.push_back(mk_word(KIND_PEEK,   5'd31));
		directed.push_back(mk_word(KIND_APPEND, 5'd5));
		// unlink from the middle, then the tail, then a non-member
		directed.push_back(mk_word(KIND_UNLINK, 5'd31));
		directed.push_back(mk_word(KIND_UNLINK, 5'd5));
		directed.push_back(mk_word(KIND_UNLINK, 5'd5));
		// unlink the only entry: queue goes empty
		directed.push_back(mk_word(KIND_UNLINK, 5'd0));
		directed.push_back(mk_word(KIND_PEEK,   5'd0));
		// refill after empty, unlink the head with a successor
		directed.push_back(mk_word(KIND_APPEND, 5'd7));
		directed.push_back(mk_word(KIND_APPEND, 5'd8));
		directed.push_back(mk_word(KIND_APPEND, 5'd9));
		directed.push_back(mk_word(KIND_UNLINK, 5'd7));
		directed.push_back(mk_word(KIND_PEEK,   5'd0));
		directed.push_back(mk_word(KIND_POP,    5'd0));
		directed.push_back(mk_word(KIND_POP,    5'd0));
		directed.push_back(mk_word(KIND_POP,    5'd0));
		directed.push_back(mk_word(KIND_APPEND, 5'd31));
		directed.push_back(mk_word(KIND_POP,    5'd0));
		foreach (directed[i])
			send_word(directed[i]);
		wait_drained();

		for (int ph = 0; ph < 20; ph++) begin
			// some phases run flat out on one or both sides
			req_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 10;
			rsp_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 10;
			if (ph == 2) begin
				// back-pressure: receiver parks, sender keeps pushing until stalled
				req_gap_max = 0;
				hold_rsp    = 1'b1;
			end
			for (int n = 0; n < 97; n++)
				send_word(random_word(ph[0]));
			if (ph % 4 == 3)
				wait_drained();
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (sb.pending() != 0)
			sb.report("words never returned", 0, sb.pending());
		if (sb.fails == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
